// ===== rtl/ivpd_pkg.sv =====
// Package for the joint PD controller core: field widths, item kinds and
// controller sequencing states. No dependencies.
package ivpd_pkg;

	localparam int NUM_JOINTS_DEF = 7;

	localparam int KIND_W  = 2;
	localparam int JOINT_W = 3;
	localparam int ANGLE_W = 32;
	localparam int DT_W    = 24;
	localparam int GAIN_W  = 20;
	localparam int TORQUE_W = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_STEP  = 2'd0,
		KIND_START = 2'd1,
		KIND_STOP  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INC,
		ST_CLAMP,
		ST_TORQUE,
		ST_OUT
	} state_t;

endpackage

// ===== rtl/ivpd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependencies.
module ivpd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/integrated_velocity_pd_joint_core.sv =====
// Joint PD controller core: per-joint target memory, integration, clamp and
// torque computation. Uses ivpd_pkg and ivpd_ram.
//
// Usage: the input channel carries one request per joint per control period
// (valid/stall). A start request latches the measured position as the joint
// target and clears the finished flag; a stop request sets the flag. Neither
// produces a result. A step request produces one
// result (joint_out, torque, finished, target_position) on the output channel.
// Requests with an unused kind or a joint index of NUM_JOINTS or more are dropped.
//
// Step sequence: the target memory is read at the edge that accepts a step
// request, then come increment multiply, clamp and write-back, stiffness
// multiply, and rounding into the output register. The input is stalled
// until the result is in that register, so no new request is taken while
// a step is in flight. The sequence is set by the single read/write
// port pair of the target memory and the registered multiplier stages.
// Reset clears the per-joint valid bits so every target reads as zero, and sets
// the finished flag. When the receiver stalls, the result holds in the output
// register; a following step waits in its last stage until the register frees.
module integrated_velocity_pd_joint_core
	import ivpd_pkg::*;
#(
	parameter int NUM_JOINTS = NUM_JOINTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [KIND_W-1:0]          kind,
	input  logic [JOINT_W-1:0]         joint,
	input  logic signed [ANGLE_W-1:0]  position,
	input  logic signed [ANGLE_W-1:0]  velocity,
	input  logic signed [ANGLE_W-1:0]  target_velocity,
	input  logic [DT_W-1:0]            time_step,
	input  logic [GAIN_W-1:0]          stiffness,
	input  logic [GAIN_W-1:0]          damping,
	input  logic signed [ANGLE_W-1:0]  lower_limit,
	input  logic signed [ANGLE_W-1:0]  upper_limit,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [JOINT_W-1:0]         joint_out,
	output logic signed [TORQUE_W-1:0] torque,
	output logic                       finished,
	output logic signed [ANGLE_W-1:0]  target_position
);

	localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
	localparam int JX_W = (AW > JOINT_W) ? AW : JOINT_W;

	localparam logic signed [56:0] INC_HALF = 57'sd8388608;
	localparam logic signed [54:0] TQ_HALF  = 55'sd524288;
	localparam logic signed [34:0] TQ_MAX   = 35'sd2147483647;
	localparam logic signed [34:0] TQ_MIN   = -35'sd2147483648;

	state_t state_q, state_nxt;

	logic                      in_acc;
	logic                      joint_ok;
	logic [JX_W-1:0]           joint_x;
	logic [AW-1:0]             in_addr;
	kind_t                     in_kind;

	logic [NUM_JOINTS-1:0]     valid_q;
	logic                      done_q;

	// latched step request
	logic [JOINT_W-1:0]        jnt_q;
	logic [AW-1:0]             addr_q;
	logic signed [ANGLE_W-1:0] pos_q, vel_q, tvel_q, lo_q, hi_q;
	logic [DT_W-1:0]           dt_q;
	logic [GAIN_W-1:0]         kp_q, kd_q;

	// datapath registers
	logic signed [31:0]        base_s1;
	logic signed [56:0]        prod_s1;
	logic signed [31:0]        tgt_s2;
	logic signed [52:0]        dv_s2;
	logic signed [53:0]        p_s3;

	// memory port
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [31:0]               ram_wdata;
	logic [31:0]               ram_rdata;

	// control decodes
	logic                      do_latch, do_base, do_clamp, do_torque, do_out;
	logic                      out_free;

	// combinational datapath
	logic signed [24:0]        dt_sx;
	logic signed [56:0]        inc_prod;
	logic signed [56:0]        inc_rnd;
	logic signed [33:0]        tgt_sum, hi_x, lo_x, tgt_hi, tgt_lo;
	logic signed [31:0]        tgt_new;
	logic signed [20:0]        kp_sx, kd_sx;
	logic signed [52:0]        dv_prod;
	logic signed [32:0]        diff;
	logic signed [53:0]        p_prod;
	logic signed [54:0]        acc, acc_rnd;
	logic signed [34:0]        tq_wide;
	logic signed [31:0]        tq_sat;

	assign in_kind  = kind_t'(kind);
	assign joint_x  = JX_W'(joint);
	assign in_addr  = joint_x[AW-1:0];
	assign joint_ok = (32'(joint) < NUM_JOINTS);
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	ivpd_ram #(
		.WIDTH(32),
		.DEPTH(NUM_JOINTS),
		.AW   (AW)
	) u_tgt_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(in_addr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && joint_ok && in_kind == KIND_STEP)
					state_nxt = ST_INC;
			end
			ST_INC:    state_nxt = ST_CLAMP;
			ST_CLAMP:  state_nxt = ST_TORQUE;
			ST_TORQUE: state_nxt = ST_OUT;
			ST_OUT: begin
				if (out_free)
					state_nxt = ST_IDLE;
			end
			default:   state_nxt = ST_IDLE;
		endcase
	end

	// stage controls
	always_comb begin
		do_latch  = 1'b0;
		do_base   = 1'b0;
		do_clamp  = 1'b0;
		do_torque = 1'b0;
		do_out    = 1'b0;
		unique case (state_q)
			ST_IDLE:   do_latch  = in_acc;
			ST_INC:    do_base   = 1'b1;
			ST_CLAMP:  do_clamp  = 1'b1;
			ST_TORQUE: do_torque = 1'b1;
			ST_OUT:    do_out    = out_free;
			default:   do_latch  = 1'b0;
		endcase
	end

	// memory write: start requests at acceptance, step write-back at clamp
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = in_addr;
		ram_wdata = position;
		if (do_latch && joint_ok && in_kind == KIND_START) begin
			ram_we = 1'b1;
		end else if (do_clamp) begin
			ram_we    = 1'b1;
			ram_waddr = addr_q;
			ram_wdata = tgt_new;
		end
	end

	// increment: round time_step * target_velocity from Q3.52 to Q3.28
	assign dt_sx    = $signed({1'b0, dt_q});
	assign inc_prod = dt_sx * tvel_q;
	assign inc_rnd  = prod_s1 + INC_HALF;

	// integrate and clamp: upper limit first, then lower
	assign tgt_sum = $signed({{2{base_s1[31]}}, base_s1})
		+ $signed({inc_rnd[56], inc_rnd[56:24]});
	assign hi_x    = $signed({{2{hi_q[31]}}, hi_q});
	assign lo_x    = $signed({{2{lo_q[31]}}, lo_q});
	assign tgt_hi  = (tgt_sum > hi_x) ? hi_x : tgt_sum;
	assign tgt_lo  = (tgt_hi < lo_x) ? lo_x : tgt_hi;
	assign tgt_new = tgt_lo[31:0];

	assign kd_sx   = $signed({1'b0, kd_q});
	assign dv_prod = kd_sx * vel_q;

	assign kp_sx   = $signed({1'b0, kp_q});
	assign diff    = $signed({tgt_s2[31], tgt_s2}) - $signed({pos_q[31], pos_q});
	assign p_prod  = kp_sx * diff;

	// torque: round Q.36 to Q15.16, then saturate
	assign acc     = $signed({p_s3[53], p_s3}) - $signed({{2{dv_s2[52]}}, dv_s2});
	assign acc_rnd = acc + TQ_HALF;
	assign tq_wide = acc_rnd[54:20];

	always_comb begin
		priority if (tq_wide > TQ_MAX)
			tq_sat = TQ_MAX[31:0];
		else if (tq_wide < TQ_MIN)
			tq_sat = TQ_MIN[31:0];
		else
			tq_sat = tq_wide[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			done_q    <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ram_we)
				valid_q[ram_waddr] <= 1'b1;
			if (do_latch && joint_ok) begin
				if (in_kind == KIND_START)
					done_q <= 1'b0;
				else if (in_kind == KIND_STOP)
					done_q <= 1'b1;
			end
			if (do_out)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_latch) begin
			jnt_q  <= joint;
			addr_q <= in_addr;
			pos_q  <= position;
			vel_q  <= velocity;
			tvel_q <= target_velocity;
			dt_q   <= time_step;
			kp_q   <= stiffness;
			kd_q   <= damping;
			lo_q   <= lower_limit;
			hi_q   <= upper_limit;
		end
		if (do_base) begin
			// never-written entries read as the reset value zero
			base_s1 <= valid_q[addr_q] ? $signed(ram_rdata) : 32'sd0;
			prod_s1 <= inc_prod;
		end
		if (do_clamp) begin
			tgt_s2 <= tgt_new;
			dv_s2  <= dv_prod;
		end
		if (do_torque)
			p_s3 <= p_prod;
		if (do_out) begin
			joint_out       <= jnt_q;
			torque          <= tq_sat;
			finished        <= done_q;
			target_position <= tgt_s2;
		end
	end

endmodule

// ===== test/tb_integrated_velocity_pd_joint_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for integrated_velocity_pd_joint_core: directed and random
// requests with random idling on both channels, checked against a local predictor.
// Depends on ivpd_pkg and the core RTL only.
module tb_integrated_velocity_pd_joint_core;
	import ivpd_pkg::*;

	localparam int NJ = NUM_JOINTS_DEF;
	localparam int N_RANDOM = 1425;
	localparam int STALL_LIMIT = 1000;
	localparam logic signed [ANGLE_W-1:0] ANG_MIN = 32'sh8000_0000;
	localparam logic signed [ANGLE_W-1:0] ANG_MAX = 32'sh7FFF_FFFF;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 20'hF_FFFF;
	localparam logic [DT_W-1:0] DT_MAX = 24'hFF_FFFF;

	typedef struct {
		kind_t                      kind;
		logic [JOINT_W-1:0]         joint;
		logic signed [ANGLE_W-1:0]  position;
		logic signed [ANGLE_W-1:0]  velocity;
		logic signed [ANGLE_W-1:0]  target_velocity;
		logic [DT_W-1:0]            time_step;
		logic [GAIN_W-1:0]          stiffness;
		logic [GAIN_W-1:0]          damping;
		logic signed [ANGLE_W-1:0]  lower_limit;
		logic signed [ANGLE_W-1:0]  upper_limit;
	} joint_req_t;

	typedef struct {
		logic [JOINT_W-1:0]         joint;
		logic signed [TORQUE_W-1:0] torque;
		logic                       finished;
		logic signed [ANGLE_W-1:0]  target;
	} torque_res_t;

	typedef struct {
		joint_req_t  rq;
		bit          pinned;
		torque_res_t pin;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [KIND_W-1:0] kind = '0;
	logic [JOINT_W-1:0] joint = '0;
	logic signed [ANGLE_W-1:0] position = '0;
	logic signed [ANGLE_W-1:0] velocity = '0;
	logic signed [ANGLE_W-1:0] target_velocity = '0;
	logic [DT_W-1:0] time_step = '0;
	logic [GAIN_W-1:0] stiffness = '0;
	logic [GAIN_W-1:0] damping = '0;
	logic signed [ANGLE_W-1:0] lower_limit = '0;
	logic signed [ANGLE_W-1:0] upper_limit = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [JOINT_W-1:0] joint_out;
	logic signed [TORQUE_W-1:0] torque;
	logic finished;
	logic signed [ANGLE_W-1:0] target_position;

	// predictor state
	logic signed [ANGLE_W-1:0] tgt_mem [NJ] = '{default: '0};
	bit stopped = 1'b1;

	torque_res_t torque_due[$];
	stim_row_t rows[$];
	int bad_count = 0;
	int idle_cycles = 0;
	int rx_hold = 0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	integrated_velocity_pd_joint_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.joint(joint),
		.position(position),
		.velocity(velocity),
		.target_velocity(target_velocity),
		.time_step(time_step),
		.stiffness(stiffness),
		.damping(damping),
		.lower_limit(lower_limit),
		.upper_limit(upper_limit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.joint_out(joint_out),
		.torque(torque),
		.finished(finished),
		.target_position(target_position)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic joint_req_t mk(kind_t k, logic [JOINT_W-1:0] j,
			logic signed [ANGLE_W-1:0] p, logic signed [ANGLE_W-1:0] v,
			logic signed [ANGLE_W-1:0] tv, logic [DT_W-1:0] dt,
			logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] kd,
			logic signed [ANGLE_W-1:0] lo, logic signed [ANGLE_W-1:0] hi);
		joint_req_t r;
		r.kind = k;
		r.joint = j;
		r.position = p;
		r.velocity = v;
		r.target_velocity = tv;
		r.time_step = dt;
		r.stiffness = kp;
		r.damping = kd;
		r.lower_limit = lo;
		r.upper_limit = hi;
		return r;
	endfunction

	// Update the per-joint targets and the finished flag; return 1 with the torque
	// result when the request is a step on a valid joint.
	function automatic bit predict_torque(input joint_req_t r, output torque_res_t res);
		longint inc, tgt, acc, tq;
		res = '{default: '0};
		if (r.joint >= NJ)
			return 0;
		case (r.kind)
			KIND_START: begin
				tgt_mem[r.joint] = r.position;
				stopped = 1'b0;
				return 0;
			end
			KIND_STOP: begin
				stopped = 1'b1;
				return 0;
			end
			KIND_STEP: ;
			default: return 0;
		endcase
		// Q0.24 * Q3.28 -> Q3.52, round half up back to Q3.28
		inc = (longint'(r.time_step) * longint'(r.target_velocity)
			+ (longint'(1) << 23)) >>> 24;
		tgt = longint'(tgt_mem[r.joint]) + inc;
		if (tgt > longint'(r.upper_limit))
			tgt = longint'(r.upper_limit);
		if (tgt < longint'(r.lower_limit))
			tgt = longint'(r.lower_limit);
		tgt_mem[r.joint] = tgt[31:0];
		acc = longint'(r.stiffness) * (tgt - longint'(r.position))
			- longint'(r.damping) * longint'(r.velocity);
		tq = (acc + (longint'(1) << 19)) >>> 20;
		if (tq > longint'(ANG_MAX))
			tq = longint'(ANG_MAX);
		if (tq < longint'(ANG_MIN))
			tq = longint'(ANG_MIN);
		res.joint = r.joint;
		res.torque = tq[31:0];
		res.finished = stopped;
		res.target = tgt[31:0];
		return 1;
	endfunction

	function automatic logic signed [ANGLE_W-1:0] draw_angle();
		case ($urandom_range(0, 11))
			0: return ANG_MIN;
			1: return ANG_MAX;
			2, 3: return $urandom();
			default: return int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] draw_gain();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return GAIN_MAX;
			2, 3, 4: return GAIN_W'($urandom());
			default: return GAIN_W'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic offer(input joint_req_t r, input bit pinned, input torque_res_t pin);
		int gap;
		torque_res_t pr;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= r.kind;
		joint <= r.joint;
		position <= r.position;
		velocity <= r.velocity;
		target_velocity <= r.target_velocity;
		time_step <= r.time_step;
		stiffness <= r.stiffness;
		damping <= r.damping;
		lower_limit <= r.lower_limit;
		upper_limit <= r.upper_limit;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (predict_torque(r, pr))
			torque_due.push_back(pinned ? pin : pr);
	endtask

	task automatic take_result();
		torque_res_t e;
		if (torque_due.size() == 0) begin
			bad_count++;
			if (bad_count <= 10)
				$display("unexpected result: joint %0d torque %h finished %b target %h",
					joint_out, torque, finished, target_position);
		end else begin
			e = torque_due.pop_front();
			if (joint_out !== e.joint || torque !== e.torque || finished !== e.finished
					|| target_position !== e.target) begin
				bad_count++;
				if (bad_count <= 10)
					$display("mismatch: expected %0d %h %b %h, actual %0d %h %b %h",
						e.joint, e.torque, e.finished, e.target,
						joint_out, torque, finished, target_position);
			end
		end
	endtask

	// receiver: check accepted results, then hold off for a random number of cycles
	always @(posedge clk) begin
		int w;
		logic nxt;
		if (arst_n) begin
			nxt = 1'b0;
			if (out_valid && !out_stall) begin
				take_result();
				if ($urandom_range(0, 39) == 0)
					rx_burst = !rx_burst;
				w = rx_burst ? 0 : $urandom_range(0, 14);
				if (w > 0) begin
					nxt = 1'b1;
					rx_hold = w - 1;
				end
			end else if (rx_hold > 0) begin
				nxt = 1'b1;
				rx_hold--;
			end
			out_stall <= nxt;
		end
	end

	// watchdog: count cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		joint_req_t r;
		int pick;
		logic [JOINT_W-1:0] j;
		logic signed [ANGLE_W-1:0] lo, hi, sw;
		logic [DT_W-1:0] dt;
		torque_res_t none;
		none = '{default: '0};

		rows.push_back('{mk(KIND_STEP, 0, 0, 0, 0, 0, 256, 256, ANG_MIN, ANG_MAX), 1'b1,
			'{3'd0, 32'sd0, 1'b1, 32'sd0}});
		rows.push_back('{mk(KIND_NONE, 1, 5, 5, 5, 5, 5, 5, ANG_MIN, ANG_MAX), 1'b0, none});
		rows.push_back('{mk(KIND_STEP, 7, 5, 5, 5, 5, 5, 5, ANG_MIN, ANG_MAX), 1'b0, none});
		// start on an out-of-range joint must not clear the finished flag
		rows.push_back('{mk(KIND_START, 7, 5, 0, 0, 0, 0, 0, ANG_MIN, ANG_MAX), 1'b0, none});
		rows.push_back('{mk(KIND_STEP, 0, 0, 0, 0, 0, 256, 256, ANG_MIN, ANG_MAX), 1'b1,
			'{3'd0, 32'sd0, 1'b1, 32'sd0}});
		rows.push_back('{mk(KIND_START, 1, 32'sh1000_0000, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
		rows.push_back('{mk(KIND_STEP, 1, 32'sh1000_0000, 0, 0, 0, 512, 512, ANG_MIN, ANG_MAX),
			1'b1, '{3'd1, 32'sd0, 1'b0, 32'sh1000_0000}});
		rows.push_back('{mk(KIND_STEP, 1, 0, ANG_MAX, ANG_MAX, DT_MAX, GAIN_MAX, GAIN_MAX,
			ANG_MIN, ANG_MAX), 1'b0, none});
		// torque saturation, both directions
		rows.push_back('{mk(KIND_STEP, 2, ANG_MIN, ANG_MIN, 0, 0, GAIN_MAX, GAIN_MAX,
			ANG_MIN, ANG_MAX), 1'b1, '{3'd2, ANG_MAX, 1'b0, 32'sd0}});
		rows.push_back('{mk(KIND_STEP, 3, ANG_MAX, ANG_MAX, 0, 0, GAIN_MAX, GAIN_MAX,
			ANG_MIN, ANG_MAX), 1'b1, '{3'd3, ANG_MIN, 1'b0, 32'sd0}});
		// crossed limits: lower wins
		rows.push_back('{mk(KIND_STEP, 4, 32'sh0100_0000, 0, 0, 0, 1000, 1000,
			32'sh0100_0000, 32'sh00F0_0000), 1'b1, '{3'd4, 32'sd0, 1'b0, 32'sh0100_0000}});
		rows.push_back('{mk(KIND_STEP, 5, 32'sh0010_0000, 0, ANG_MAX, DT_MAX, 77, 77,
			ANG_MIN, 32'sh0010_0000), 1'b1, '{3'd5, 32'sd0, 1'b0, 32'sh0010_0000}});
		rows.push_back('{mk(KIND_STEP, 6, 32'shFFF0_0000, 0, ANG_MIN, DT_MAX, 77, 77,
			32'shFFF0_0000, ANG_MAX), 1'b1, '{3'd6, 32'sd0, 1'b0, 32'shFFF0_0000}});
		rows.push_back('{mk(KIND_STOP, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
		rows.push_back('{mk(KIND_STEP, 6, 32'shFFF0_0000, 0, 0, 0, 300, 300, ANG_MIN, ANG_MAX),
			1'b1, '{3'd6, 32'sd0, 1'b1, 32'shFFF0_0000}});
		rows.push_back('{mk(KIND_START, 7, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
		rows.push_back('{mk(KIND_STEP, 6, 32'shFFF0_0000, 0, 0, 0, 300, 300, ANG_MIN, ANG_MAX),
			1'b1, '{3'd6, 32'sd0, 1'b1, 32'shFFF0_0000}});
		rows.push_back('{mk(KIND_START, 0, 32'sh0000_0100, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
		// increment rounding: half rounds up, just below half rounds down
		rows.push_back('{mk(KIND_STEP, 0, 32'sh0000_0100, 0, 32'sh0080_0000, 1, 256, 0,
			ANG_MIN, ANG_MAX), 1'b1, '{3'd0, 32'sd0, 1'b0, 32'sh0000_0101}});
		rows.push_back('{mk(KIND_STEP, 0, 32'sh0000_0101, 0, 32'shFF80_0000, 1, 256, 0,
			ANG_MIN, ANG_MAX), 1'b1, '{3'd0, 32'sd0, 1'b0, 32'sh0000_0101}});
		rows.push_back('{mk(KIND_STEP, 0, 32'sh0000_0100, 0, 32'shFF7F_FFFF, 1, 256, 0,
			ANG_MIN, ANG_MAX), 1'b1, '{3'd0, 32'sd0, 1'b0, 32'sh0000_0100}});
		rows.push_back('{mk(KIND_STEP, 3, 32'sh0123_4567, 32'shFEDC_BA98, 32'sh0200_0000,
			24'd16777, 20'h0_2800, 20'h0_0180, 32'shE000_0000, 32'sh2000_0000), 1'b0, none});
		rows.push_back('{mk(KIND_NONE, 7, ANG_MAX, ANG_MIN, ANG_MAX, DT_MAX, GAIN_MAX, GAIN_MAX,
			ANG_MIN, ANG_MAX), 1'b0, none});
		rows.push_back('{mk(KIND_STOP, 7, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
		rows.push_back('{mk(KIND_STEP, 1, 32'sh0F00_0000, 32'sh0010_0000, 32'shF000_0000,
			24'd40000, 20'h0_1000, 20'h0_0800, ANG_MIN, ANG_MAX), 1'b0, none});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		@(posedge clk);

		foreach (rows[i])
			offer(rows[i].rq, rows[i].pinned, rows[i].pin);

		for (int n = 0; n < N_RANDOM; n++) begin
			pick = $urandom_range(0, 99);
			j = ($urandom_range(0, 19) == 0) ? 3'd7 : 3'($urandom_range(0, NJ - 1));
			lo = draw_angle();
			hi = draw_angle();
			// mostly ordered limits; crossed ones now and then
			if (lo > hi && $urandom_range(0, 6) != 0) begin
				sw = lo;
				lo = hi;
				hi = sw;
			end
			case ($urandom_range(0, 9))
				0: dt = '0;
				1: dt = DT_MAX;
				2, 3: dt = DT_W'($urandom());
				default: dt = DT_W'($urandom_range(0, 65535));
			endcase
			r = mk(pick < 68 ? KIND_STEP : pick < 82 ? KIND_START : pick < 94 ? KIND_STOP
				: KIND_NONE, j, draw_angle(), draw_angle(), draw_angle(), dt,
				draw_gain(), draw_gain(), lo, hi);
			offer(r, 1'b0, none);
		end
		in_valid <= 1'b0;

		while (torque_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (bad_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ivpd_pkg.sv
rtl/ivpd_ram.sv
rtl/integrated_velocity_pd_joint_core.sv
test/tb_integrated_velocity_pd_joint_core.sv
